// ===== rtl/core/ap2c_pkg.sv =====
`timescale 1ns / 1ps
package ap2c_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 8;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_BITS   = $clog2(LINE_DEPTH);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = 11;
    localparam int ROW_BITS   = 11;
    localparam int LIMIT_BITS = 8;
    localparam int PAIR_BITS  = SAMPLE_BITS + 1;
    localparam int SUM_BITS   = SAMPLE_BITS + 2;
    localparam int CFG_BITS   = WIDTH_BITS;
    localparam int CFG_ADDR_BITS = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET  = WIDTH_BITS'(10);
    localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET  = LIMIT_BITS'(65);
    localparam logic [LIMIT_BITS-1:0] HIGH_LIMIT_RESET = LIMIT_BITS'(85);
    localparam logic [WIDTH_BITS-1:0] MIN_ROW_WIDTH    = WIDTH_BITS'(2);
    localparam logic [WIDTH_BITS-1:0] MAX_ROW_WIDTH    = WIDTH_BITS'(MAX_WIDTH);

    localparam logic [CFG_ADDR_BITS-1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HIGH_LIMIT = 2'd2;

    localparam logic [1:0] CLASS_LOW  = 2'd0;
    localparam logic [1:0] CLASS_MID  = 2'd1;
    localparam logic [1:0] CLASS_HIGH = 2'd2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [SUM_BITS-1:0]  window_sum;
        logic [1:0]           level_class;
        logic [IDX_BITS-1:0]  block_column;
        logic [ROW_BITS-2:0]  block_row;
    } t_out_item;

    // One unit of work for the back end: store a pair sum, or finish a window.
    typedef struct packed {
        logic                  is_finish;
        logic [IDX_BITS-1:0]   idx;
        logic [PAIR_BITS-1:0]  pair;
        logic [ROW_BITS-2:0]   block_row;
    } t_pool_op;

endpackage

// ===== rtl/core/ap2c_front.sv =====
`timescale 1ns / 1ps
module ap2c_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ap2c_pkg::t_in_item                  i_in_data,
    input  logic [ap2c_pkg::WIDTH_BITS-1:0]     i_row_width,
    input  logic                                i_q_full,
    output logic                                o_push,
    output ap2c_pkg::t_pool_op                  o_push_op
);
    import ap2c_pkg::*;

    logic [COL_BITS-1:0]    r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [SAMPLE_BITS-1:0] r_left, n_left;

    logic [WIDTH_BITS-1:0]  w_use;
    logic [WIDTH_BITS-1:0]  pair_cols;
    logic [COL_BITS-1:0]    col;
    logic [ROW_BITS-1:0]    row;
    logic [WIDTH_BITS-1:0]  col_ext;
    logic                   in_pair;
    logic                   accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        if (i_row_width < MIN_ROW_WIDTH) begin
            w_use = MIN_ROW_WIDTH;
        end else if (i_row_width > MAX_ROW_WIDTH) begin
            w_use = MAX_ROW_WIDTH;
        end else begin
            w_use = i_row_width;
        end
        pair_cols = {w_use[WIDTH_BITS-1:1], 1'b0};

        col = i_in_data.first_of_frame ? '0 : r_col;
        row = i_in_data.first_of_frame ? '0 : r_row;
        col_ext = WIDTH_BITS'(col);
        in_pair = col_ext < pair_cols;

        o_push              = accept && in_pair && col[0];
        o_push_op.is_finish = row[0];
        o_push_op.idx       = col[COL_BITS-1:1];
        o_push_op.pair      = PAIR_BITS'(r_left) + PAIR_BITS'(i_in_data.sample);
        o_push_op.block_row = row[ROW_BITS-1:1];

        n_col  = r_col;
        n_row  = r_row;
        n_left = r_left;
        if (accept) begin
            if (in_pair && !col[0]) begin
                n_left = i_in_data.sample;
            end
            // A sample at or beyond the last usable column closes the row.
            if ((col_ext + WIDTH_BITS'(1)) >= w_use) begin
                n_col = '0;
                n_row = row + ROW_BITS'(1);
            end else begin
                n_col = col + COL_BITS'(1);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= n_left;
        end
    end

endmodule

// ===== rtl/core/ap2c_op_fifo.sv =====
`timescale 1ns / 1ps
module ap2c_op_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ap2c_pkg::t_pool_op  i_push_op,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output ap2c_pkg::t_pool_op  o_op
);
    import ap2c_pkg::*;

    t_pool_op                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count, n_count;
    logic                     do_pop;

    assign o_full  = r_count == FIFO_CNT_BITS'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_op    = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + FIFO_PTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + FIFO_PTR_BITS'(1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + FIFO_CNT_BITS'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - FIFO_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/ap2c_back.sv =====
`timescale 1ns / 1ps
module ap2c_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_op_valid,
    input  ap2c_pkg::t_pool_op                  i_op,
    output logic                                o_pop,
    input  logic [ap2c_pkg::LIMIT_BITS-1:0]     i_low_limit,
    input  logic [ap2c_pkg::LIMIT_BITS-1:0]     i_high_limit,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ap2c_pkg::t_out_item                 o_out_data
);
    import ap2c_pkg::*;

    logic [PAIR_BITS-1:0] r_line [LINE_DEPTH];

    logic                 r_b_valid;
    logic [PAIR_BITS-1:0] r_b_above;
    logic [PAIR_BITS-1:0] r_b_pair;
    logic [IDX_BITS-1:0]  r_b_idx;
    logic [ROW_BITS-2:0]  r_b_brow;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 adv;
    logic [SUM_BITS-1:0]  sum;
    logic [1:0]           level;

    // The whole back pipeline moves together whenever the output slot frees.
    assign adv   = !r_out_valid || i_out_ready;
    assign o_pop = adv && i_op_valid;

    always_comb begin
        sum = SUM_BITS'(r_b_above) + SUM_BITS'(r_b_pair);
        if (sum <= {i_low_limit, 2'b00}) begin
            level = CLASS_LOW;
        end else if (sum <= {i_high_limit, 2'b00}) begin
            level = CLASS_MID;
        end else begin
            level = CLASS_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_op.is_finish) begin
                r_b_above <= r_line[i_op.idx];
            end else begin
                r_line[i_op.idx] <= i_op.pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_pair <= i_op.pair;
            r_b_idx  <= i_op.idx;
            r_b_brow <= i_op.block_row;
        end
        if (adv && r_b_valid) begin
            r_out.window_sum   <= sum;
            r_out.level_class  <= level;
            r_out.block_column <= r_b_idx;
            r_out.block_row    <= r_b_brow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid   <= o_pop && i_op.is_finish;
            r_out_valid <= r_b_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/avg_pool_2x2_classify.sv =====
`timescale 1ns / 1ps
// 2x2 average pooling with three-band classification. Samples enter one per
// clock in raster order; a result leaves for every finished window, carrying
// the window sum (the average with two fraction bits), its class and its
// pooled column and row. The block sustains one sample per cycle: the front
// end updates the counters and the pair sum in the cycle a sample is taken,
// and the back end does one line-store access per cycle on the single port
// of the 512-entry pair line. A result is valid once the sample completing its
// window has passed through the operation queue into the registered read of
// the pair line and then through the output register. A stalled output backs
// up into the four-entry queue, and the input stalls only once that queue is
// full. Configuration must be written only while the block is idle; the block
// itself does not enforce this. The pair line holds garbage after reset until
// an even row has written it.
module avg_pool_2x2_classify (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ap2c_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [ap2c_pkg::CFG_BITS-1:0]       i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ap2c_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ap2c_pkg::t_out_item                 o_out_data
);
    import ap2c_pkg::*;

    logic [WIDTH_BITS-1:0] r_row_width;
    logic [LIMIT_BITS-1:0] r_low_limit;
    logic [LIMIT_BITS-1:0] r_high_limit;

    logic     q_full;
    logic     push;
    t_pool_op push_op;
    logic     pop;
    logic     op_valid;
    t_pool_op op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width  <= ROW_WIDTH_RESET;
            r_low_limit  <= LOW_LIMIT_RESET;
            r_high_limit <= HIGH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROW_WIDTH:  r_row_width  <= i_cfg_wdata[WIDTH_BITS-1:0];
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_wdata[LIMIT_BITS-1:0];
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_wdata[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    ap2c_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_row_width (r_row_width),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_op   (push_op)
    );

    ap2c_op_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .o_full    (q_full),
        .i_pop     (pop),
        .o_valid   (op_valid),
        .o_op      (op)
    );

    ap2c_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (op_valid),
        .i_op         (op),
        .o_pop        (pop),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // No result can be pending right after a reset cycle.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.level_class <= CLASS_HIGH))
        else $error("undefined class code");

    a_low_class_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.level_class == CLASS_LOW))
            |-> (o_out_data.window_sum <= {r_low_limit, 2'b00}))
        else $error("low class with sum above low limit");

    a_high_class_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.level_class == CLASS_HIGH))
            |-> (o_out_data.window_sum > {r_high_limit, 2'b00}))
        else $error("high class with sum at or below high limit");

endmodule

// ===== sim/avg_pool_2x2_classify_tb.sv =====
`timescale 1ns / 1ps
module avg_pool_2x2_classify_tb;
    import ap2c_pkg::*;

    localparam int          HALF_PERIOD   = 10;
    localparam int          RESET_CYCLES  = 4;
    localparam int          DRAIN_CYCLES  = 12;
    localparam int          RANDOM_ITEMS  = 100;
    localparam int          WIDE_EXTRA    = 160;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          MAX_REPORTS   = 20;
    localparam int          LONG_HOLD     = 300;
    localparam int          HOLD_AT_COUNT = 40;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [CFG_BITS-1:0]      i_cfg_wdata = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_data;

    avg_pool_2x2_classify dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Shadow of the block: configuration, line of pair sums and raster position.
    logic [WIDTH_BITS-1:0] cfg_width = ROW_WIDTH_RESET;
    logic [LIMIT_BITS-1:0] cfg_low   = LOW_LIMIT_RESET;
    logic [LIMIT_BITS-1:0] cfg_high  = HIGH_LIMIT_RESET;
    logic [PAIR_BITS-1:0]  pair_sums [LINE_DEPTH];
    bit                    pair_valid [LINE_DEPTH];
    logic [SAMPLE_BITS-1:0] left_px  = '0;
    logic [COL_BITS-1:0]   col_pos   = '0;
    logic [ROW_BITS-1:0]   row_pos   = '0;

    t_in_item  sample_requests [$];
    t_out_item windows_due [$];

    int  n_taken = 0;
    int  n_windows = 0;
    int  n_errors = 0;
    int  n_runs = 0;
    int  n_random = 0;
    int  cycle_cnt = 0;
    int  gap_left = 0;
    int  hold_cnt = 0;
    bit  src_burst = 1'b0;
    bit  sink_burst = 1'b0;
    bit  long_hold_done = 1'b0;

    function automatic int unsigned usable_width(input logic [WIDTH_BITS-1:0] w);
        if (w < MIN_ROW_WIDTH) return 32'(MIN_ROW_WIDTH);
        if (w > MAX_ROW_WIDTH) return 32'(MAX_ROW_WIDTH);
        return 32'(w);
    endfunction

    function automatic logic [1:0] level_band(input logic [SUM_BITS-1:0] sum);
        if (sum <= {cfg_low, 2'b00}) return CLASS_LOW;
        if (sum <= {cfg_high, 2'b00}) return CLASS_MID;
        return CLASS_HIGH;
    endfunction

    // True when every line entry that the given width reads has been filled.
    function automatic bit line_ready(input logic [WIDTH_BITS-1:0] w);
        bit ok;
        ok = 1'b1;
        for (int i = 0; i < usable_width(w) / 2; i++)
            if (!pair_valid[i]) ok = 1'b0;
        return ok;
    endfunction

    task automatic take_sample(input t_in_item it);
        int unsigned          w;
        int unsigned          c;
        int unsigned          idx;
        logic [PAIR_BITS-1:0] pair;
        logic [SUM_BITS-1:0]  sum;
        t_out_item            res;
        w = usable_width(cfg_width);
        if (it.first_of_frame) begin
            col_pos = '0;
            row_pos = '0;
        end
        c = 32'(col_pos);
        if (c < (w / 2) * 2) begin
            if (c % 2 == 0) begin
                left_px = it.sample;
            end else begin
                idx  = c / 2;
                pair = {1'b0, left_px} + {1'b0, it.sample};
                if (!row_pos[0]) begin
                    pair_sums[idx]  = pair;
                    pair_valid[idx] = 1'b1;
                end else begin
                    sum = {1'b0, pair_sums[idx]} + {1'b0, pair};
                    res.window_sum   = sum;
                    res.level_class  = level_band(sum);
                    res.block_column = idx[IDX_BITS-1:0];
                    res.block_row    = row_pos[ROW_BITS-1:1];
                    windows_due.push_back(res);
                end
            end
        end
        if (c + 1 >= w) begin
            col_pos = '0;
            row_pos = row_pos + ROW_BITS'(1);
        end else begin
            col_pos = COL_BITS'(c + 1);
        end
    endtask

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 255;
            2, 3: v = int'(cfg_low) + int'($urandom_range(0, 2)) - 1;
            4: v = int'(cfg_high) + int'($urandom_range(0, 2)) - 1;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [LIMIT_BITS-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return LIMIT_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WIDTH_BITS-1:0] pick_width();
        case ($urandom_range(0, 19))
            0: return WIDTH_BITS'($urandom_range(0, 1));
            1, 2: return WIDTH_BITS'($urandom_range(41, 160));
            default: return WIDTH_BITS'($urandom_range(2, 40));
        endcase
    endfunction

    task automatic push_request(input logic [SAMPLE_BITS-1:0] s, input bit fof);
        t_in_item it;
        it.sample         = s;
        it.first_of_frame = fof;
        sample_requests.push_back(it);
    endtask

    // Noise is a stray frame start in the middle of a row.
    task automatic queue_run(input int n, input bit start_frame, input bit noisy);
        for (int i = 0; i < n; i++)
            push_request(pick_sample(),
                         (i == 0) ? start_frame : (noisy && $urandom_range(0, 79) == 0));
        n_runs++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            CFG_ROW_WIDTH:  cfg_width = value;
            CFG_LOW_LIMIT:  cfg_low   = value[LIMIT_BITS-1:0];
            CFG_HIGH_LIMIT: cfg_high  = value[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Waits until every request is taken and every window has come out, then
    // lets the back end finish any line-store write still in flight.
    task automatic drain();
        while (sample_requests.size() != 0 || i_in_valid || windows_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_sample(i_in_data);
                n_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (sample_requests.size() != 0) begin
                    i_in_data  <= sample_requests.pop_front();
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 59) == 0) src_burst = !src_burst;
                    gap_left = src_burst ? 0 : pause_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver side: checks each window and throttles the output.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (windows_due.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: unexpected window: sum %0d class %0d col %0d row %0d",
                                 $time, o_out_data.window_sum, o_out_data.level_class,
                                 o_out_data.block_column, o_out_data.block_row);
                end else begin
                    if (o_out_data.window_sum   !== windows_due[0].window_sum   ||
                        o_out_data.level_class  !== windows_due[0].level_class  ||
                        o_out_data.block_column !== windows_due[0].block_column ||
                        o_out_data.block_row    !== windows_due[0].block_row) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("%0t: window mismatch: expected sum %0d class %0d col %0d row %0d, got sum %0d class %0d col %0d row %0d",
                                     $time, windows_due[0].window_sum,
                                     windows_due[0].level_class, windows_due[0].block_column,
                                     windows_due[0].block_row, o_out_data.window_sum,
                                     o_out_data.level_class, o_out_data.block_column,
                                     o_out_data.block_row);
                    end
                    void'(windows_due.pop_front());
                end
                n_windows++;
            end
            // One long stall in the middle of a wide odd row fills the block up.
            if (n_windows == HOLD_AT_COUNT && !long_hold_done) begin
                hold_cnt = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if ($urandom_range(0, 149) == 0) sink_burst = !sink_burst;
            if (hold_cnt == 0 && !sink_burst && $urandom_range(0, 99) < 20)
                hold_cnt = pause_len() + 1;
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] directed [24];
        bit                     start;
        directed = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd65, 8'd65, 8'd65, 8'd66, 8'd85, 8'd85,
                     8'd0, 8'd0, 8'd255, 8'd255, 8'd65, 8'd65, 8'd65, 8'd65, 8'd85, 8'd86,
                     8'd17, 8'd200, 8'd3, 8'd4};
        foreach (pair_valid[i]) pair_valid[i] = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: zero and full-scale windows, a sum right at the low limit
        // and sums just past each limit, then an even row that never gets its partner.
        foreach (directed[i]) push_request(directed[i], i == 0);
        drain();

        // Odd row width drops the last column; extreme limits.
        write_reg(CFG_ROW_WIDTH, 11'd3);
        write_reg(CFG_LOW_LIMIT, 11'd0);
        write_reg(CFG_HIGH_LIMIT, 11'd255);
        queue_run(60, 1'b1, 1'b1);
        drain();

        // Width above the maximum acts as the maximum; limits out of order.
        // One full row fills the line, then part of the odd row follows.
        write_reg(CFG_ROW_WIDTH, 11'd2047);
        write_reg(CFG_LOW_LIMIT, 11'd200);
        write_reg(CFG_HIGH_LIMIT, 11'd100);
        queue_run(MAX_WIDTH + WIDE_EXTRA, 1'b1, 1'b0);
        drain();

        // Width zero acts as two.
        write_reg(CFG_ROW_WIDTH, 11'd0);
        write_reg(CFG_LOW_LIMIT, CFG_BITS'(pick_limit()));
        write_reg(CFG_HIGH_LIMIT, CFG_BITS'(pick_limit()));
        queue_run(40, 1'b1, 1'b0);
        drain();

        write_reg(CFG_ROW_WIDTH, 11'd1);
        write_reg(CFG_LOW_LIMIT, 11'd255);
        write_reg(CFG_HIGH_LIMIT, 11'd0);
        queue_run(40, 1'b1, 1'b1);
        drain();

        // Shrinking the width mid-row: the next sample lies past the usable
        // pairs, is dropped and ends the row.
        write_reg(CFG_ROW_WIDTH, 11'd1024);
        write_reg(CFG_LOW_LIMIT, 11'd60);
        write_reg(CFG_HIGH_LIMIT, 11'd140);
        queue_run(30, 1'b1, 1'b0);
        drain();
        write_reg(CFG_ROW_WIDTH, 11'd7);
        queue_run(40, 1'b0, 1'b0);
        drain();

        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) write_reg(CFG_ROW_WIDTH, pick_width());
            if ($urandom_range(0, 1)) write_reg(CFG_LOW_LIMIT, CFG_BITS'(pick_limit()));
            if ($urandom_range(0, 1)) write_reg(CFG_HIGH_LIMIT, CFG_BITS'(pick_limit()));
            // A wider row must not reach line entries that were never filled.
            start = !line_ready(cfg_width) || $urandom_range(0, 2) == 0;
            begin : one_run
                int n;
                n = $urandom_range(10, 150);
                queue_run(n, start, 1'b1);
                n_random += n;
            end
            drain();
        end

        $display("Summary: %0d samples in %0d runs, %0d windows checked, %0d errors.",
                 n_taken, n_runs, n_windows, n_errors);
        $display("Covered widths 0 to 2047, odd widths, mid-row width change, stalls.");
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
